// ===== rtl/bma_pkg.sv =====
// Package for the bit manipulation ALU: command codes, item structs, helpers.
// No dependencies.
package bma_pkg;

  typedef enum logic [3:0] {
    CMD_BZHI   = 4'd0,
    CMD_BEXTR  = 4'd1,
    CMD_SHLX   = 4'd2,
    CMD_SARX   = 4'd3,
    CMD_SHRX   = 4'd4,
    CMD_MULX   = 4'd5,
    CMD_RORX   = 4'd6,
    CMD_PEXT   = 4'd7,
    CMD_PDEP   = 4'd8,
    CMD_ANDN   = 4'd9,
    CMD_BLSR   = 4'd10,
    CMD_BLSMSK = 4'd11,
    CMD_BLSI   = 4'd12
  } cmd_t;

  localparam logic [63:0] MASK32 = 64'h0000_0000_ffff_ffff;

  typedef struct packed {
    logic [3:0]  command;
    logic        wide;
    logic [63:0] operand_rm;
    logic [63:0] operand_v;
    logic [63:0] operand_rdx;
    logic [7:0]  rotate_imm;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result;
    logic [63:0] low_product;
    logic        low_valid;
    logic        flags_written;
    logic        zero_flag;
    logic        sign_flag;
    logic        carry_flag;
    logic        status;
  } out_item_t;

  // Low n bits set (n up to 64)
  function automatic logic [63:0] lowbits(input logic [6:0] n);
    logic [127:0] t;
    t = (128'd1 << n) - 128'd1;
    return t[63:0];
  endfunction

endpackage

// ===== rtl/bma_pdep_pext.sv =====
// Two-stage PEXT/PDEP network: prefix counts of the mask in stage 1,
// bit routing in stage 2. Depends on bma_pkg.
module bma_pdep_pext
  import bma_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] mask,
  input  logic [63:0] src,
  output logic [63:0] pext_res,
  output logic [63:0] pdep_res
);

  // Stage 1: rank of each mask bit (set bits below it)
  logic [6:0]  rank [64];
  logic [6:0]  rank_q [64];
  logic [63:0] mask_q;
  logic [63:0] src_q;
  logic [3:0]  lcnt [64];
  logic [6:0]  bbase [8];

  // Two-level prefix count: running count inside each byte, then byte bases
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      lcnt[8*b] = 4'd0;
      for (int j = 1; j < 8; j++) begin
        lcnt[8*b+j] = lcnt[8*b+j-1] + {3'd0, mask[8*b+j-1]};
      end
    end
    bbase[0] = 7'd0;
    for (int b = 1; b < 8; b++) begin
      bbase[b] = bbase[b-1] + {3'd0, lcnt[8*b-1]} + {6'd0, mask[8*b-1]};
    end
    for (int i = 0; i < 64; i++) begin
      rank[i] = bbase[i >> 3] + {3'd0, lcnt[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rank_q <= rank;
      mask_q <= mask;
      src_q  <= src;
    end
  end

  // Stage 2: route bits by rank
  logic [63:0] pe, pd;
  always_comb begin
    pe = '0;
    pd = '0;
    for (int i = 0; i < 64; i++) begin
      pd[i] = mask_q[i] & src_q[rank_q[i][5:0]];
      for (int k = 0; k < 64; k++) begin
        if (mask_q[i] && rank_q[i] == 7'(k)) pe[k] = src_q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pext_res <= pe;
      pdep_res <= pd;
    end
  end

endmodule

// ===== rtl/bit_manipulation_alu.sv =====
// Top level of the bit manipulation ALU: four-stage pipeline with handshake.
// Depends on bma_pkg and bma_pdep_pext.

// Executes one BMI1/BMI2 operation per item at 32 or 64 bits. An item enters
// in every cycle unless a finished result is held by a stall, and its result
// is presented at the output after four register stages (operand masking,
// partial products and mask ranks, product sum and routing, flags). While a
// valid result is held by a stall on the output, the whole pipeline freezes
// and the input is stalled.
module bit_manipulation_alu
  import bma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic en;
  logic [3:0] vld;
  assign en        = ~(vld[3] & out_stall);
  assign in_stall  = ~en;
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // Stage 1: mask operands, simple operations
  logic [63:0] m0, rm0, v0, rdx0, simple0;
  logic [6:0]  wb0;
  logic [5:0]  sh0, rot0;
  logic        cf0, fl0, st0, lv0;
  logic [127:0] rr;

  always_comb begin
    m0   = in_item.wide ? '1 : MASK32;
    wb0  = in_item.wide ? 7'd64 : 7'd32;
    rm0  = in_item.operand_rm & m0;
    v0   = in_item.operand_v & m0;
    rdx0 = in_item.operand_rdx & m0;
    sh0  = v0[5:0] & (wb0[5:0] - 6'd1);
    rot0 = in_item.rotate_imm[5:0] & (wb0[5:0] - 6'd1);
    simple0 = '0;
    cf0 = 1'b0;
    fl0 = 1'b0;
    st0 = 1'b0;
    lv0 = 1'b0;
    rr  = '0;
    case (in_item.command)
      CMD_BZHI: begin
        fl0 = 1'b1;
        if ({1'b0, v0[7:0]} >= {2'b0, wb0}) begin
          simple0 = rm0;
          cf0 = 1'b1;
        end else begin
          simple0 = rm0 & lowbits(v0[6:0]);
        end
      end
      CMD_BEXTR: begin
        fl0 = 1'b1;
        simple0 = ({1'b0, v0[7:0]} >= {2'b0, wb0}) ? '0 : (rm0 >> v0[5:0]);
        if ({1'b0, v0[15:8]} < {2'b0, wb0}) simple0 = simple0 & lowbits(v0[14:8]);
      end
      CMD_SHLX: simple0 = rm0 << sh0;
      CMD_SARX: begin
        simple0 = rm0 >> sh0;
        if (rm0[wb0[5:0] - 6'd1] | (in_item.wide & rm0[63]))
          simple0 = simple0 | (m0 & ~(m0 >> sh0));
      end
      CMD_SHRX: simple0 = rm0 >> sh0;
      CMD_MULX: lv0 = 1'b1;
      CMD_RORX: begin
        if (in_item.wide) rr = {rm0, rm0} >> rot0;
        else rr = {64'd0, rm0[31:0], rm0[31:0]} >> rot0;
        simple0 = rr[63:0];
      end
      CMD_PEXT, CMD_PDEP: simple0 = '0;
      CMD_ANDN: begin
        fl0 = 1'b1;
        simple0 = ~v0 & rm0;
      end
      CMD_BLSR: begin
        fl0 = 1'b1;
        simple0 = (rm0 - 64'd1) & rm0;
        cf0 = (rm0 == '0);
      end
      CMD_BLSMSK: begin
        fl0 = 1'b1;
        simple0 = (rm0 - 64'd1) ^ rm0;
        cf0 = (rm0 == '0);
      end
      CMD_BLSI: begin
        fl0 = 1'b1;
        simple0 = (64'd0 - rm0) & rm0;
        cf0 = (rm0 != '0);
      end
      default: st0 = 1'b1;
    endcase
  end

  logic [3:0]  cmd1;
  logic        w1, cf1, fl1, st1, lv1;
  logic [63:0] m1, rm1, v1, rdx1, simple1;
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= in_item.command;
      w1 <= in_item.wide;
      m1 <= m0;
      rm1 <= rm0;
      v1 <= v0;
      rdx1 <= rdx0;
      simple1 <= simple0 & m0;
      cf1 <= cf0;
      fl1 <= fl0;
      st1 <= st0;
      lv1 <= lv0;
    end
  end

  // Stage 2: 32x32 partial products
  logic [63:0] p00, p01, p10, p11;
  logic [3:0]  cmd2;
  logic        w2, cf2, fl2, st2, lv2;
  logic [63:0] m2, simple2;
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= rdx1[31:0] * rm1[31:0];
      p01 <= rdx1[31:0] * rm1[63:32];
      p10 <= rdx1[63:32] * rm1[31:0];
      p11 <= rdx1[63:32] * rm1[63:32];
      cmd2 <= cmd1;
      w2 <= w1;
      m2 <= m1;
      simple2 <= simple1;
      cf2 <= cf1;
      fl2 <= fl1;
      st2 <= st1;
      lv2 <= lv1;
    end
  end

  // PEXT/PDEP network spans stages 2 and 3
  logic [63:0] pext3, pdep3;
  bma_pdep_pext u_pp (
    .clk(clk), .en(en), .mask(rm1), .src(v1),
    .pext_res(pext3), .pdep_res(pdep3)
  );

  // Stage 3: sum partial products, pick main result
  logic [127:0] prod;
  logic [63:0]  res2;
  assign prod = {64'd0, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32)
              + {p11, 64'd0};

  logic [63:0] res3, low3, m3;
  logic        w3, cf3, fl3, st3, lv3;
  always_ff @(posedge clk) begin
    if (en) begin
      res3 <= res2;
      low3 <= '0;
      if (cmd2 == CMD_MULX) low3 <= w2 ? prod[63:0] : {32'd0, prod[31:0]};
      m3 <= m2;
      w3 <= w2;
      cf3 <= cf2;
      fl3 <= fl2;
      st3 <= st2;
      lv3 <= lv2;
    end
  end

  always_comb begin
    case (cmd2)
      CMD_MULX: res2 = w2 ? prod[127:64] : {32'd0, prod[63:32]};
      default:  res2 = simple2;
    endcase
  end

  // PEXT/PDEP outputs arrive with stage 3; select there
  logic [3:0] cmd3;
  always_ff @(posedge clk) begin
    if (en) cmd3 <= cmd2;
  end

  // Stage 4: final select and flags
  logic [63:0] fin3;
  always_comb begin
    case (cmd3)
      CMD_PEXT: fin3 = pext3 & m3;
      CMD_PDEP: fin3 = pdep3 & m3;
      default:  fin3 = res3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.result        <= fin3;
      out_item.low_product   <= low3;
      out_item.low_valid     <= lv3;
      out_item.flags_written <= fl3;
      out_item.zero_flag     <= fl3 & (fin3 == '0);
      out_item.sign_flag     <= fl3 & (w3 ? fin3[63] : fin3[31]);
      out_item.carry_flag    <= fl3 & cf3;
      out_item.status        <= st3;
    end
  end

  // Checks
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output changed under stall");
  a_mulx_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.low_valid && out_item.flags_written))
    else $error("mulx wrote flags");
  a_unimpl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |-> out_item.result == '0 && !out_item.low_valid)
    else $error("unimplemented command gave a result");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.flags_written |->
      !out_item.zero_flag && !out_item.sign_flag && !out_item.carry_flag)
    else $error("flags without flag write");

endmodule

// ===== bench/tb_bit_manipulation_alu.sv =====
// Testbench for the bit manipulation ALU: directed and random BMI1/BMI2 items
// checked in order against a behavioral predictor. Depends on bma_pkg and the RTL.
module tb_bit_manipulation_alu;
  import bma_pkg::*;

  // In-order store of predicted ALU results
  class alu_scoreboard;
    out_item_t pending[$];
    int errors;
    int checked;

    function automatic logic [63:0] low_mask(int n);
      if (n <= 0) return 64'd0;
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    // Compute the expected result of one instruction
    function automatic out_item_t predict(in_item_t it);
      out_item_t o;
      logic [63:0] m, rm, v, rdx, t;
      logic [127:0] prod;
      int wb, sh, r, k, idx, start, len;
      logic cf, setfl;
      o = '0;
      cf = 1'b0;
      setfl = 1'b0;
      wb = it.wide ? 64 : 32;
      m = it.wide ? '1 : MASK32;
      rm = it.operand_rm & m;
      v = it.operand_v & m;
      rdx = it.operand_rdx & m;
      sh = int'(v & 64'(wb - 1));
      case (it.command)
        CMD_BZHI: begin
          idx = int'(v[7:0]);
          if (idx >= wb) begin
            o.result = rm;
            cf = 1'b1;
          end else o.result = rm & low_mask(idx);
          setfl = 1'b1;
        end
        CMD_BEXTR: begin
          start = int'(v[7:0]);
          len = int'(v[15:8]);
          t = (start >= wb) ? 64'd0 : (rm >> start);
          o.result = (len >= wb) ? t : (t & low_mask(len));
          setfl = 1'b1;
        end
        CMD_SHLX: o.result = rm << sh;
        CMD_SARX: begin
          o.result = rm >> sh;
          if (rm[wb-1]) o.result |= m & ~(m >> sh);
        end
        CMD_SHRX: o.result = rm >> sh;
        CMD_MULX: begin
          prod = rdx * rm;
          if (it.wide) begin
            o.result = prod[127:64];
            o.low_product = prod[63:0];
          end else begin
            o.result = prod[63:32];
            o.low_product = prod[31:0];
          end
          o.low_valid = 1'b1;
        end
        CMD_RORX: begin
          r = int'(it.rotate_imm) & (wb - 1);
          o.result = (r == 0) ? rm : ((rm >> r) | (rm << (wb - r)));
        end
        CMD_PEXT: begin
          k = 0;
          for (int i = 0; i < 64; i++)
            if (rm[i]) begin
              o.result[k] = v[i];
              k++;
            end
        end
        CMD_PDEP: begin
          k = 0;
          for (int i = 0; i < 64; i++)
            if (rm[i]) begin
              o.result[i] = v[k];
              k++;
            end
        end
        CMD_ANDN: begin
          o.result = ~v & rm;
          setfl = 1'b1;
        end
        CMD_BLSR: begin
          o.result = (rm - 64'd1) & rm;
          cf = (rm == 0);
          setfl = 1'b1;
        end
        CMD_BLSMSK: begin
          o.result = (rm - 64'd1) ^ rm;
          cf = (rm == 0);
          setfl = 1'b1;
        end
        CMD_BLSI: begin
          o.result = (64'd0 - rm) & rm;
          cf = (rm != 0);
          setfl = 1'b1;
        end
        default: o.status = 1'b1;
      endcase
      o.result &= m;
      o.low_product &= m;
      o.flags_written = setfl;
      if (setfl) begin
        o.zero_flag = (o.result == 0);
        o.sign_flag = o.result[wb-1];
        o.carry_flag = cf;
      end
      return o;
    endfunction

    function void note_input(in_item_t it);
      pending.push_back(predict(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.result !== exp.result)
        $display("%0t: result exp %h got %h", $time, exp.result, got.result);
      if (got.low_product !== exp.low_product)
        $display("%0t: low_product exp %h got %h", $time, exp.low_product,
                 got.low_product);
      if (got.low_valid !== exp.low_valid)
        $display("%0t: low_valid exp %b got %b", $time, exp.low_valid, got.low_valid);
      if (got.flags_written !== exp.flags_written)
        $display("%0t: flags_written exp %b got %b", $time, exp.flags_written,
                 got.flags_written);
      if (got.zero_flag !== exp.zero_flag)
        $display("%0t: zero_flag exp %b got %b", $time, exp.zero_flag, got.zero_flag);
      if (got.sign_flag !== exp.sign_flag)
        $display("%0t: sign_flag exp %b got %b", $time, exp.sign_flag, got.sign_flag);
      if (got.carry_flag !== exp.carry_flag)
        $display("%0t: carry_flag exp %b got %b", $time, exp.carry_flag,
                 got.carry_flag);
      if (got.status !== exp.status)
        $display("%0t: status exp %b got %b", $time, exp.status, got.status);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_item;
  out_item_t out_item;
  int send_idle_pct, recv_idle_pct;
  int directed_count, random_count;
  alu_scoreboard board;

  bit_manipulation_alu i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("bit_manipulation_alu test failed");
    $finish;
  end

  // Receiver: random stall, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) board.check_result(out_item);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Operand with a bias toward edge values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return 64'h8000_0000;
      4: return 64'h0000_0000_ffff_ffff;
      5: return 64'(int'($urandom_range(130)));
      default: return rand64();
    endcase
  endfunction

  // Present one item and hold it until accepted
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic send_op(logic [3:0] cmd, logic w, logic [63:0] rm, logic [63:0] v,
                         logic [63:0] rdx, logic [7:0] imm);
    in_item_t it;
    it.command = cmd;
    it.wide = w;
    it.operand_rm = rm;
    it.operand_v = v;
    it.operand_rdx = rdx;
    it.rotate_imm = imm;
    send_item(it);
  endtask

  task automatic send_random(int n);
    logic [63:0] v;
    for (int i = 0; i < n; i++) begin
      v = pick_operand();
      // bextr start:len fields near the width boundary
      if ($urandom_range(3) == 0) v[15:0] = {8'($urandom_range(70)), 8'($urandom_range(70))};
      send_op(4'($urandom_range(15)), 1'($urandom), pick_operand(), v, pick_operand(),
              8'($urandom));
      random_count++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    send_idle_pct = 31;
    recv_idle_pct = 77;
    directed_count = 0;
    random_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command code at 64 bits, plus boundary cases at both widths
    for (int c = 0; c < 16; c += 1) begin
      send_op(4'(c), 1'b1, '1, '1, '1, 8'hff);
      directed_count++;
    end
    send_op(CMD_BZHI, 1'b0, 64'hdead_beef_1234_5678, 64'd32, 64'd0, 8'd0);
    send_op(CMD_BZHI, 1'b1, 64'hdead_beef_1234_5678, 64'd7, 64'd0, 8'd0);
    send_op(CMD_BEXTR, 1'b0, 64'hffff_ffff_8765_4321, 64'h0820, 64'd0, 8'd0);
    send_op(CMD_BEXTR, 1'b1, 64'h8765_4321_0fed_cba9, 64'hff04, 64'd0, 8'd0);
    send_op(CMD_SARX, 1'b0, 64'h8000_0000, 64'd31, 64'd0, 8'd0);
    send_op(CMD_BLSR, 1'b1, 64'd0, 64'd0, 64'd0, 8'd0);
    send_op(CMD_BLSMSK, 1'b0, 64'hffff_ffff_0000_0000, 64'd0, 64'd0, 8'd0);
    send_op(CMD_BLSI, 1'b1, 64'h8000_0000_0000_0000, 64'd0, 64'd0, 8'd0);
    send_op(CMD_MULX, 1'b0, 64'hffff_ffff, 64'd0, 64'hffff_ffff, 8'd0);
    directed_count += 9;
    in_valid <= 1'b0;

    send_random(500);
    drain();
    send_idle_pct = 77;
    recv_idle_pct = 31;
    send_random(500);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(500);
    drain();

    $display("Ran %0d directed and %0d random items, %0d results checked.",
             directed_count, random_count, board.checked);
    $display("Covered all commands, both widths, three idle patterns.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("bit_manipulation_alu test passed");
    else
      $display("bit_manipulation_alu test failed");
    $finish;
  end

endmodule
